FILE: hw/rtl/tbrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbrl_pkg;

    // Fixed-point widths: tokens and rates Q24.16, seconds Q8.24
    localparam int TOKEN_W = 40;
    localparam int TIME_W  = 32;
    localparam int HALF_W  = 20;
    localparam int PROD_W  = HALF_W + TIME_W;
    localparam int SUM_W   = PROD_W + HALF_W;
    localparam int FRAC_SHIFT = 24;

    localparam logic [TOKEN_W-1:0] ONE_TOKEN  = 40'h00_0001_0000;
    localparam logic [TOKEN_W-1:0] TOKEN_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic [TIME_W-1:0]  ONE_SECOND = 32'h0100_0000;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [1:0] REG_ENABLED   = 2'd0;
    localparam logic [1:0] REG_MAX_RATE  = 2'd1;
    localparam logic [1:0] REG_MAX_DELAY = 2'd2;

    // Input kind codes
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_UPDATE  = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Internal operation carried down the pipeline
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_REQ    = 3'd1,
        OP_UPD    = 3'd2,
        OP_NOP    = 3'd3,
        OP_RELOAD = 3'd4
    } op_t;

    typedef struct packed {
        logic               enabled;
        logic [TOKEN_W-1:0] max_rate;
        logic [TIME_W-1:0]  max_delay;
    } cfg_t;

    typedef struct packed {
        logic               vld;
        logic [TOKEN_W-1:0] rate;
        logic [TIME_W-1:0]  delay;
    } reload_t;

    typedef struct packed {
        op_t                op;
        logic [TOKEN_W-1:0] rate;
        logic [TIME_W-1:0]  span;
    } op_beat_t;

    typedef struct packed {
        op_t                op;
        logic [TOKEN_W-1:0] value;
    } scale_beat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tbrl_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module tbrl_cfg
    import tbrl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg,
    output reload_t                reload
);

    logic               enabled_reg;
    logic [TOKEN_W-1:0] max_rate_reg;
    logic [TIME_W-1:0]  max_delay_reg;
    logic               wr;
    logic [1:0]         idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:3];

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b1;
            max_rate_reg  <= '0;
            max_delay_reg <= ONE_SECOND;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_ENABLED:   enabled_reg   <= pwdata[0];
                REG_MAX_RATE:  max_rate_reg  <= pwdata[TOKEN_W-1:0];
                REG_MAX_DELAY: max_delay_reg <= pwdata[TIME_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_ENABLED:   prdata = {{(DATA_W-1){1'b0}}, enabled_reg};
            REG_MAX_RATE:  prdata = {{(DATA_W-TOKEN_W){1'b0}}, max_rate_reg};
            REG_MAX_DELAY: prdata = {{(DATA_W-TIME_W){1'b0}}, max_delay_reg};
            default:       prdata = '0;
        endcase
    end

    // Request a rate and capacity reload with the freshly written values
    always_comb
    begin
        reload.vld   = wr && ((idx == REG_MAX_RATE) || (idx == REG_MAX_DELAY));
        reload.rate  = (idx == REG_MAX_RATE)  ? pwdata[TOKEN_W-1:0] : max_rate_reg;
        reload.delay = (idx == REG_MAX_DELAY) ? pwdata[TIME_W-1:0]  : max_delay_reg;
    end

    assign cfg.enabled   = enabled_reg;
    assign cfg.max_rate  = max_rate_reg;
    assign cfg.max_delay = max_delay_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tbrl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tbrl_front
    import tbrl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [TIME_W-1:0]  elapsed,
    input  wire logic [TOKEN_W-1:0] new_limit,
    input  wire cfg_t               cfg,
    input  wire reload_t            reload,
    output logic                    beat_vld,
    output op_beat_t                beat,
    input  wire logic               beat_ready
);

    logic               in_vld_reg;
    logic [1:0]         kind_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [TOKEN_W-1:0] new_limit_reg;
    logic               s1_vld_reg;
    op_beat_t           s1_beat_reg;
    op_beat_t           s1_beat_next;
    logic [TOKEN_W-1:0] leak_rate_reg;
    logic [TOKEN_W-1:0] limit_sel;
    logic               s1_ready;
    logic               advance;
    logic               take;

    assign s1_ready = !s1_vld_reg || beat_ready;
    assign advance  = in_vld_reg && s1_ready;
    assign in_stall = in_vld_reg && !s1_ready;
    assign take     = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (take)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg      <= kind;
            elapsed_reg   <= elapsed;
            new_limit_reg <= new_limit;
        end
    end

    // Clamp the requested limit to the configured maximum
    assign limit_sel = (new_limit_reg < cfg.max_rate) ? new_limit_reg : cfg.max_rate;

    // Pick the multiplier operands for this beat
    always_comb
    begin
        s1_beat_next.rate = leak_rate_reg;
        s1_beat_next.span = elapsed_reg;
        unique case (kind_reg)
            KIND_TICK:    s1_beat_next.op = OP_TICK;
            KIND_REQUEST: s1_beat_next.op = OP_REQ;
            KIND_UPDATE:
            begin
                s1_beat_next.op   = OP_UPD;
                s1_beat_next.rate = limit_sel;
                s1_beat_next.span = cfg.max_delay;
            end
            KIND_NONE:    s1_beat_next.op = OP_NOP;
            default:      s1_beat_next.op = OP_NOP;
        endcase
    end

    // Track the leak rate in item order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            leak_rate_reg <= '0;
        else if (reload.vld)
            leak_rate_reg <= reload.rate;
        else if (advance && (kind_reg == KIND_UPDATE))
            leak_rate_reg <= limit_sel;
    end

    // Operand reg; unchecked user rule: reload arrives on empty pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (reload.vld || advance)
            s1_vld_reg <= 1'b1;
        else if (beat_ready)
            s1_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (reload.vld)
        begin
            s1_beat_reg.op   <= OP_RELOAD;
            s1_beat_reg.rate <= reload.rate;
            s1_beat_reg.span <= reload.delay;
        end
        else if (advance)
            s1_beat_reg <= s1_beat_next;
    end

    assign beat_vld = s1_vld_reg;
    assign beat     = s1_beat_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tbrl_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module tbrl_scale
    import tbrl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     beat_vld,
    input  wire op_beat_t beat,
    output logic          beat_ready,
    output logic          res_vld,
    output scale_beat_t   res,
    input  wire logic     res_ready
);

    logic              s2_vld_reg;
    op_t               s2_op_reg;
    logic [PROD_W-1:0] hi_prod_reg;
    logic [PROD_W-1:0] lo_prod_reg;
    logic [PROD_W-1:0] hi_prod_next;
    logic [PROD_W-1:0] lo_prod_next;
    logic              s3_vld_reg;
    scale_beat_t       s3_reg;
    scale_beat_t       s3_next;
    logic [SUM_W-1:0]  full_sum;
    logic              s2_ready;
    logic              s3_ready;

    assign s3_ready   = !s3_vld_reg || res_ready;
    assign s2_ready   = !s2_vld_reg || s3_ready;
    assign beat_ready = s2_ready;

    // Split the rate in halves so each product stays 20 x 32
    assign hi_prod_next = beat.rate[TOKEN_W-1:HALF_W] * beat.span;
    assign lo_prod_next = beat.rate[HALF_W-1:0] * beat.span;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (s2_ready)
            s2_vld_reg <= beat_vld;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && beat_vld)
        begin
            s2_op_reg   <= beat.op;
            hi_prod_reg <= hi_prod_next;
            lo_prod_reg <= lo_prod_next;
        end
    end

    // Join the halves, drop the fraction and saturate to 40 bits
    assign full_sum = {hi_prod_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, lo_prod_reg};

    always_comb
    begin
        s3_next.op = s2_op_reg;
        if (full_sum[SUM_W-1:FRAC_SHIFT+TOKEN_W] != '0)
            s3_next.value = TOKEN_MAX;
        else
            s3_next.value = full_sum[FRAC_SHIFT+TOKEN_W-1:FRAC_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (s3_ready)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_vld_reg)
            s3_reg <= s3_next;
    end

    assign res_vld = s3_vld_reg;
    assign res     = s3_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tbrl_bucket.sv
`timescale 1ns / 1ps
`default_nettype none

module tbrl_bucket
    import tbrl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          enabled,
    input  wire logic          beat_vld,
    input  wire scale_beat_t   beat,
    output logic               beat_ready,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               allowed,
    output logic               slot_freed,
    output logic               below_limit,
    output logic [TOKEN_W-1:0] bucket_level
);

    logic               out_vld_reg;
    logic               allowed_reg;
    logic               freed_reg;
    logic               below_reg;
    logic [TOKEN_W-1:0] level_reg;
    logic [TOKEN_W-1:0] level_next;
    logic [TOKEN_W-1:0] capacity_reg;
    logic [TOKEN_W-1:0] capacity_next;
    logic               allowed_next;
    logic               freed_next;
    logic               below_next;
    logic               take;
    logic               emit;
    logic [TOKEN_W:0]   lvl_one;
    logic [TOKEN_W+1:0] lvl_two;
    logic [TOKEN_W:0]   cap_leak;
    logic [TOKEN_W-1:0] level_drained;
    logic               room_ok;
    logic               room_two_ok;
    logic               drain_partial;
    logic               room_after_tick;
    logic               room_after_upd;

    assign beat_ready = (beat.op == OP_RELOAD) || !out_vld_reg || !out_stall;
    assign take       = beat_vld && beat_ready;
    assign emit       = take && (beat.op != OP_RELOAD);

    // Room tests, all against the present level in parallel
    assign lvl_one       = {1'b0, level_reg} + {1'b0, ONE_TOKEN};
    assign lvl_two       = {1'b0, lvl_one} + {2'b00, ONE_TOKEN};
    assign cap_leak      = {1'b0, capacity_reg} + {1'b0, beat.value};
    assign room_ok       = {1'b0, capacity_reg} >= lvl_one;
    assign room_two_ok   = {2'b00, capacity_reg} >= lvl_two;
    assign drain_partial = level_reg > beat.value;
    assign level_drained = drain_partial ? (level_reg - beat.value) : '0;
    assign room_after_tick = drain_partial ? (cap_leak >= lvl_one)
                                           : (capacity_reg >= ONE_TOKEN);
    assign room_after_upd  = {1'b0, beat.value} >= lvl_one;

    // Apply one beat to the bucket
    always_comb
    begin
        level_next    = level_reg;
        capacity_next = capacity_reg;
        allowed_next  = 1'b0;
        freed_next    = 1'b0;
        below_next    = !enabled || room_ok;
        unique case (beat.op)
            OP_TICK:
            begin
                level_next = level_drained;
                freed_next = !room_ok && room_after_tick;
                below_next = !enabled || room_after_tick;
            end
            OP_REQ:
            begin
                if (!enabled)
                    allowed_next = 1'b1;
                else if (room_ok)
                begin
                    allowed_next = 1'b1;
                    level_next   = lvl_one[TOKEN_W-1:0];
                    below_next   = room_two_ok;
                end
            end
            OP_UPD:
            begin
                capacity_next = beat.value;
                below_next    = !enabled || room_after_upd;
            end
            OP_RELOAD:
                capacity_next = beat.value;
            OP_NOP: ;
            default: ;
        endcase
    end

    // Bucket state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            capacity_reg <= '0;
        end
        else if (take)
        begin
            level_reg    <= level_next;
            capacity_reg <= capacity_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (emit)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            allowed_reg <= allowed_next;
            freed_reg   <= freed_next;
            below_reg   <= below_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign allowed      = allowed_reg;
    assign slot_freed   = freed_reg;
    assign below_limit  = below_reg;
    assign bucket_level = level_reg;

    // A reload never produces a result
    a_reload_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_vld && (beat.op == OP_RELOAD) && !out_vld_reg) |=> !out_vld_reg)
        else $error("reload produced a result beat");

    // An enforced admission keeps the level within capacity
    a_admit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (beat.op == OP_REQ) && enabled && room_ok)
            |=> (level_reg <= capacity_reg))
        else $error("admitted request overfilled the bucket");

    // A tick never raises the level
    a_tick_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (beat.op == OP_TICK)) |=> (level_reg <= $past(level_reg)))
        else $error("tick raised the bucket level");

    // A beat cannot both admit a request and free a slot
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(allowed_reg && freed_reg))
        else $error("allowed and slot_freed both set");

endmodule

`default_nettype wire

FILE: hw/rtl/token_bucket_rate_limiter_unit.sv
// Leaky-bucket rate limiter. Each input beat is a tick (drain leak_rate times
// elapsed from the level, floored at zero), a packet request (admit when the
// room left below capacity is at least one token, then add one token; while disabled
// admit without adding) or a limit update (leak rate becomes min(new_limit, max_rate),
// capacity becomes that rate times max_delay); kind 3 changes nothing. Every input
// beat yields exactly one result beat, in order. One beat is accepted per clock
// while in_stall is low; a result passes from the input register through operand
// select, two 20 x 32 partial products, join and saturate, then the bucket update
// whose level and capacity feed back through combinational logic only. A stalled
// result holds the stages behind it, and once all five registers are full the
// input stalls too.
// Tokens and rates are Q24.16, times Q8.24, and scaled products saturate to 40 bits.
// Registers sit on a 64-bit APB-style port at 0x00 (enabled), 0x08 (max_rate)
// and 0x10 (max_delay); writing max_rate or max_delay reloads the leak rate
// and recomputes the capacity through the same multiplier, so write them only
// while no beats are in flight.
`timescale 1ns / 1ps
`default_nettype none

module token_bucket_rate_limiter_unit
    import tbrl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [TIME_W-1:0]  elapsed,
    input  wire logic [TOKEN_W-1:0] new_limit,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    allowed,
    output logic                    slot_freed,
    output logic                    below_limit,
    output logic      [TOKEN_W-1:0] bucket_level
);

    cfg_t        cfg;
    reload_t     reload;
    logic        op_vld;
    op_beat_t    op_beat;
    logic        op_ready;
    logic        sc_vld;
    scale_beat_t sc_beat;
    logic        sc_ready;

    // Configuration registers
    tbrl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .reload  (reload)
    );

    // Input register and operand select
    tbrl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .elapsed    (elapsed),
        .new_limit  (new_limit),
        .cfg        (cfg),
        .reload     (reload),
        .beat_vld   (op_vld),
        .beat       (op_beat),
        .beat_ready (op_ready)
    );

    // Rate times time, saturated
    tbrl_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_vld   (op_vld),
        .beat       (op_beat),
        .beat_ready (op_ready),
        .res_vld    (sc_vld),
        .res        (sc_beat),
        .res_ready  (sc_ready)
    );

    // Bucket level, capacity and result register
    tbrl_bucket u_bucket (
        .clk          (clk),
        .rst_n        (rst_n),
        .enabled      (cfg.enabled),
        .beat_vld     (sc_vld),
        .beat         (sc_beat),
        .beat_ready   (sc_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .allowed      (allowed),
        .slot_freed   (slot_freed),
        .below_limit  (below_limit),
        .bucket_level (bucket_level)
    );

endmodule

`default_nettype wire

FILE: verif/token_bucket_rate_limiter_unit_checker.sv
`timescale 1ns / 1ps

module token_bucket_rate_limiter_unit_checker
    import tbrl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [TIME_W-1:0]  elapsed,
    input  logic [TOKEN_W-1:0] new_limit,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               allowed,
    input  logic               slot_freed,
    input  logic               below_limit,
    input  logic [TOKEN_W-1:0] bucket_level,
    output int                 mismatch_count,
    output int                 pending_count
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic               allowed;
        logic               slot_freed;
        logic               below_limit;
        logic [TOKEN_W-1:0] level;
    } bucket_result_t;

    // Register copies and bucket state
    logic               enabled_q;
    logic [TOKEN_W-1:0] max_rate_q;
    logic [TIME_W-1:0]  max_delay_q;
    logic [TOKEN_W-1:0] level_q;
    logic [TOKEN_W-1:0] leak_rate_q;
    logic [TOKEN_W-1:0] capacity_q;

    bucket_result_t bucket_results_q[$];

    // Q24.16 rate times Q8.24 span, truncated back to Q24.16, saturated to 40 bits
    function automatic logic [TOKEN_W-1:0] scale_by_time(input logic [TOKEN_W-1:0] rate,
                                                         input logic [TIME_W-1:0] span);
        logic [TOKEN_W+TIME_W-1:0] prod;
        logic [TOKEN_W+TIME_W-1:0] shifted;
        prod = rate * span;
        shifted = prod >> FRAC_SHIFT;
        if (|shifted[TOKEN_W+TIME_W-1:TOKEN_W])
            return TOKEN_MAX;
        return shifted[TOKEN_W-1:0];
    endfunction

    // Room below capacity; zero when the level sits above it
    function automatic logic [TOKEN_W-1:0] bucket_room();
        return (capacity_q > level_q) ? capacity_q - level_q : '0;
    endfunction

    function automatic void reload_bucket();
        leak_rate_q = max_rate_q;
        capacity_q = scale_by_time(max_rate_q, max_delay_q);
    endfunction

    // Advance the bucket by one input beat and return the result it produces
    function automatic bucket_result_t apply_beat_to_bucket(input logic [1:0] k,
                                                            input logic [TIME_W-1:0] span,
                                                            input logic [TOKEN_W-1:0] limit);
        bucket_result_t res;
        logic [TOKEN_W-1:0] drain;
        logic was_full;
        res = '0;
        drain = scale_by_time(leak_rate_q, span);
        if (k == KIND_TICK) begin
            // drain still applies while disabled
            was_full = bucket_room() < ONE_TOKEN;
            level_q = (level_q > drain) ? level_q - drain : '0;
            res.slot_freed = was_full && (bucket_room() >= ONE_TOKEN);
        end else if (k == KIND_REQUEST) begin
            if (!enabled_q) begin
                res.allowed = 1'b1;
            end else if (bucket_room() >= ONE_TOKEN) begin
                res.allowed = 1'b1;
                level_q = level_q + ONE_TOKEN;
            end
        end else if (k == KIND_UPDATE) begin
            leak_rate_q = (limit < max_rate_q) ? limit : max_rate_q;
            capacity_q = scale_by_time(leak_rate_q, max_delay_q);
        end
        res.below_limit = !enabled_q || (bucket_room() >= ONE_TOKEN);
        res.level = level_q;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        bucket_result_t want;
        bucket_result_t got;
        if (!rst_n) begin
            enabled_q = 1'b1;
            max_rate_q = '0;
            max_delay_q = ONE_SECOND;
            level_q = '0;
            reload_bucket();
            bucket_results_q.delete();
            mismatch_count = 0;
            pending_count = 0;
        end else begin
            // Track register writes; an unused index changes nothing
            if (psel && penable && pwrite && pready) begin
                if (paddr[ADDR_W-1:3] == REG_ENABLED) begin
                    enabled_q = pwdata[0];
                end else if (paddr[ADDR_W-1:3] == REG_MAX_RATE) begin
                    max_rate_q = pwdata[TOKEN_W-1:0];
                    reload_bucket();
                end else if (paddr[ADDR_W-1:3] == REG_MAX_DELAY) begin
                    max_delay_q = pwdata[TIME_W-1:0];
                    reload_bucket();
                end
            end

            // Compare a result beat with the oldest prediction
            if (out_valid && !out_stall) begin
                got.allowed = allowed;
                got.slot_freed = slot_freed;
                got.below_limit = below_limit;
                got.level = bucket_level;
                if (bucket_results_q.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: result beat with none pending: %s=%0b %s=%0b %s=%0b %s=%h",
                                 $time, "allowed", got.allowed, "freed", got.slot_freed,
                                 "below", got.below_limit, "level", got.level);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = bucket_results_q.pop_front();
                    if (got.allowed !== want.allowed || got.slot_freed !== want.slot_freed ||
                        got.below_limit !== want.below_limit || got.level !== want.level) begin
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("%0t: expected allowed=%0b freed=%0b below=%0b level=%h",
                                     $time, want.allowed, want.slot_freed, want.below_limit,
                                     want.level);
                            $display("%0t:   actual allowed=%0b freed=%0b below=%0b level=%h",
                                     $time, got.allowed, got.slot_freed, got.below_limit,
                                     got.level);
                        end
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end

            // Predict the result of an accepted input beat
            if (in_valid && !in_stall)
                bucket_results_q.push_back(apply_beat_to_bucket(kind, elapsed, new_limit));

            pending_count = bucket_results_q.size();
        end
    end

endmodule

FILE: verif/token_bucket_rate_limiter_unit_tb.sv
`timescale 1ns / 1ps

module token_bucket_rate_limiter_unit_tb;
    import tbrl_pkg::*;

    localparam int          RESET_CYCLES  = 7;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          NUM_PHASES    = 9;
    localparam int          PHASE_BEATS   = 167;
    localparam int unsigned TICK_SPAN_MAX = 32'h0040_0000;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [TIME_W-1:0]  elapsed;
    logic [TOKEN_W-1:0] new_limit;
    logic               out_valid;
    logic               out_stall;
    logic               allowed;
    logic               slot_freed;
    logic               below_limit;
    logic [TOKEN_W-1:0] bucket_level;

    int                 mismatch_count;
    int                 pending_count;
    int                 cycle_count;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    logic               pressure_req;
    logic               pressure_done;
    logic [TOKEN_W-1:0] cur_max_rate;

    token_bucket_rate_limiter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .elapsed      (elapsed),
        .new_limit    (new_limit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .allowed      (allowed),
        .slot_freed   (slot_freed),
        .below_limit  (below_limit),
        .bucket_level (bucket_level)
    );

    token_bucket_rate_limiter_unit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .elapsed        (elapsed),
        .new_limit      (new_limit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .allowed        (allowed),
        .slot_freed     (slot_freed),
        .below_limit    (below_limit),
        .bucket_level   (bucket_level),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off to back up the pipeline
    initial
    begin
        out_stall = 1'b0;
        pressure_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_req && !pressure_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                pressure_done = 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    function automatic logic [TOKEN_W-1:0] rand_tokens();
        return TOKEN_W'({$urandom, $urandom});
    endfunction

    // Offer one beat after a random gap; return at the falling edge after acceptance
    task automatic send_beat(input logic [1:0] k, input logic [TIME_W-1:0] span,
                             input logic [TOKEN_W-1:0] limit);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        elapsed <= span;
        new_limit <= limit;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Setup and access phase; psel stays high so writes can run back to back
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain the block, then write all registers
    task automatic configure(input logic en, input logic [TOKEN_W-1:0] rate,
                             input logic [TIME_W-1:0] delay, input logic poke_unused);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(REG_ENABLED, DATA_W'(en));
        write_reg(REG_MAX_RATE, DATA_W'(rate));
        write_reg(REG_MAX_DELAY, DATA_W'(delay));
        if (poke_unused)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_max_rate = rate;
    endtask

    // Mostly requests and short ticks so the bucket hovers around full
    task automatic send_random_beat();
        int unsigned pick;
        logic [1:0] k;
        logic [TIME_W-1:0] span;
        logic [TOKEN_W-1:0] limit;
        pick = $urandom_range(0, 99);
        span = $urandom;
        limit = rand_tokens();
        if (pick < 55)
        begin
            k = KIND_REQUEST;
        end
        else if (pick < 85)
        begin
            k = KIND_TICK;
            if ($urandom_range(0, 9) != 0)
                span = $urandom_range(0, TICK_SPAN_MAX);
        end
        else if (pick < 95)
        begin
            k = KIND_UPDATE;
            if ($urandom_range(0, 3) != 0)
                limit = cur_max_rate >> $urandom_range(0, 2);
        end
        else
        begin
            k = KIND_NONE;
        end
        send_beat(k, span, limit);
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        logic en;
        logic [TOKEN_W-1:0] rate;
        logic [TIME_W-1:0] delay;

        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_TICK;
        elapsed = '0;
        new_limit = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pressure_req = 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 50;
        cur_max_rate = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: zero rate, zero capacity
        send_beat(KIND_REQUEST, $urandom, rand_tokens());
        send_beat(KIND_TICK, '0, rand_tokens());
        send_beat(KIND_NONE, $urandom, rand_tokens());
        send_beat(KIND_UPDATE, $urandom, rand_tokens());

        // Four-token bucket: fill, overflow, free a slot, shrink below level
        configure(1'b1, 40'd4 * ONE_TOKEN, ONE_SECOND, 1'b1);
        repeat (5) send_beat(KIND_REQUEST, $urandom, rand_tokens());
        send_beat(KIND_TICK, '0, rand_tokens());
        send_beat(KIND_TICK, ONE_SECOND >> 2, rand_tokens());
        send_beat(KIND_REQUEST, $urandom, rand_tokens());
        send_beat(KIND_UPDATE, $urandom, 40'd2 * ONE_TOKEN);
        send_beat(KIND_REQUEST, $urandom, rand_tokens());
        send_beat(KIND_TICK, '1, rand_tokens());
        send_beat(KIND_UPDATE, $urandom, TOKEN_MAX);
        send_beat(KIND_NONE, $urandom, rand_tokens());

        // Disabled: admit everything, ticks still drain
        configure(1'b0, 40'd4 * ONE_TOKEN, ONE_SECOND, 1'b0);
        send_beat(KIND_REQUEST, $urandom, rand_tokens());
        send_beat(KIND_TICK, $urandom, rand_tokens());

        // Saturated products
        configure(1'b1, TOKEN_MAX, '1, 1'b0);
        send_beat(KIND_REQUEST, $urandom, rand_tokens());
        send_beat(KIND_TICK, '1, rand_tokens());
        send_beat(KIND_UPDATE, $urandom, '0);
        send_beat(KIND_REQUEST, $urandom, rand_tokens());
        send_beat(KIND_UPDATE, $urandom, TOKEN_MAX);
        send_beat(KIND_REQUEST, $urandom, rand_tokens());

        // Random phases over several settings and idle patterns
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            en = (phase != 4);
            rate = TOKEN_W'($urandom_range(1, 16)) * ONE_TOKEN
                   + TOKEN_W'($urandom_range(0, 16'hFFFF));
            delay = TIME_W'($urandom_range(1, 6)) * ONE_SECOND + ($urandom & 32'h00FF_FFFF);
            if (phase == 2)
                rate = rand_tokens();
            if (phase == 5)
            begin
                rate = TOKEN_MAX;
                delay = '1;
            end
            if (phase == 8)
                delay = $urandom_range(1, 32'h0010_0000);
            configure(en, rate, delay, 1'b0);

            if (phase < 3)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 50;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 0)
                pressure_req = 1'b1;

            for (n = 0; n < PHASE_BEATS; n++)
                send_random_beat();
        end

        // Drain and report
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
